>>> src/jps_pkg.sv
`timescale 1ns / 1ps
package jps_pkg;

	localparam int MAX_DIM    = 1024;
	localparam int LINE_LEN   = MAX_DIM + 2;
	localparam int ADDR_W     = $clog2(LINE_LEN);
	localparam int CNT_W      = ADDR_W;
	localparam int DIM_W      = 11;
	localparam int IDX_W      = 10;
	localparam int VAL_W      = 32;
	localparam int COEF_W     = 24;
	localparam int CD_W       = 32;
	localparam int COEF_FRAC  = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// operand and product widths, all exact
	localparam int HS_W  = VAL_W + 1;
	localparam int PH_W  = HS_W + COEF_W + 1;
	localparam int PD_W  = VAL_W + CD_W + 1;
	localparam int ACC_W = PD_W + 2;
	localparam int Q_W   = ACC_W - COEF_FRAC;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_HORIZONTAL = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_VERTICAL   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_DENSITY    = CFG_IDX_W'(4);

	localparam logic [DIM_W-1:0]  ROW_COUNT_RST = DIM_W'(100);
	localparam logic [DIM_W-1:0]  COL_COUNT_RST = DIM_W'(100);
	localparam logic [COEF_W-1:0] COEF_H_RST    = COEF_W'(4194304);
	localparam logic [COEF_W-1:0] COEF_V_RST    = COEF_W'(4194304);
	localparam logic [CD_W-1:0]   COEF_D_RST    = CD_W'(1678);

	typedef struct packed {
		logic signed [VAL_W-1:0] old_value;
		logic signed [VAL_W-1:0] density_value;
	} item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] new_value;
		logic [IDX_W-1:0]        row_index;
		logic [IDX_W-1:0]        column_index;
		logic                    frame_last;
	} result_t;

	// last padded row/column index and coefficients, as seen by the datapath
	typedef struct packed {
		logic [CNT_W-1:0]  last_row;
		logic [CNT_W-1:0]  last_col;
		logic [COEF_W-1:0] coef_h;
		logic [COEF_W-1:0] coef_v;
		logic [CD_W-1:0]   coef_d;
	} dims_t;

	typedef struct packed {
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] column_index;
		logic             frame_last;
	} tag_t;

	typedef struct packed {
		logic signed [HS_W-1:0]  hsum;
		logic signed [HS_W-1:0]  vsum;
		logic signed [VAL_W-1:0] rho;
		tag_t                    tag;
	} opnd_t;

endpackage

>>> src/jps_ram.sv
`timescale 1ns / 1ps
module jps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1026
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/jps_cfg.sv
`timescale 1ns / 1ps
module jps_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [jps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jps_pkg::CFG_DATA_W-1:0]   cfg_data,
	output jps_pkg::dims_t                   dims
);
	import jps_pkg::*;

	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

	logic [DIM_W-1:0]  rows_q;
	logic [DIM_W-1:0]  cols_q;
	logic [COEF_W-1:0] coef_h_q;
	logic [COEF_W-1:0] coef_v_q;
	logic [CD_W-1:0]   coef_d_q;
	logic              wr;

	// padded last index: clamp the interior count to 1..MAX_DIM, then add one
	function automatic logic [CNT_W-1:0] pad_last(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] c;
		if (v == '0) begin
			c = DIM_W'(1);
		end else if (v > DIM_MAX) begin
			c = DIM_MAX;
		end else begin
			c = v;
		end
		return CNT_W'(c) + CNT_W'(1);
	endfunction

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= ROW_COUNT_RST;
			cols_q   <= COL_COUNT_RST;
			coef_h_q <= COEF_H_RST;
			coef_v_q <= COEF_V_RST;
			coef_d_q <= COEF_D_RST;
		end else if (wr) begin
			unique case (cfg_index)
				REG_ROW_COUNT:       rows_q   <= cfg_data[DIM_W-1:0];
				REG_COLUMN_COUNT:    cols_q   <= cfg_data[DIM_W-1:0];
				REG_COEF_HORIZONTAL: coef_h_q <= cfg_data[COEF_W-1:0];
				REG_COEF_VERTICAL:   coef_v_q <= cfg_data[COEF_W-1:0];
				REG_COEF_DENSITY:    coef_d_q <= cfg_data[CD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		dims.last_row = pad_last(rows_q);
		dims.last_col = pad_last(cols_q);
		dims.coef_h   = coef_h_q;
		dims.coef_v   = coef_v_q;
		dims.coef_d   = coef_d_q;
	end

endmodule

>>> src/jps_window.sv
`timescale 1ns / 1ps
module jps_window (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  jps_pkg::item_t  item,
	input  jps_pkg::dims_t  dims,
	output logic            opnd_valid,
	input  logic            opnd_ready,
	output jps_pkg::opnd_t  opnd
);
	import jps_pkg::*;

	logic [CNT_W-1:0] row_q, col_q;
	logic             accept, ready_s1, ready_s2, pass_s1;
	logic             row_end, frame_end, hit;

	logic [VAL_W-1:0] rd0, rd1, rdd;
	logic [VAL_W-1:0] mid_rd, up_rd;

	logic             valid_s1, bank_s1, hit_s1;
	tag_t             tag_s1;
	logic [VAL_W-1:0] x_s1;

	// window history over the previous accepted beats
	logic [VAL_W-1:0] r1_q, r2_q, u1_q, x1_q, d1_q;

	logic             valid_s2;
	opnd_t            opnd_s2;

	assign ready_s2   = !valid_s2 || opnd_ready;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign item_stall = !ready_s1;
	assign accept     = item_valid && ready_s1;
	assign pass_s1    = valid_s1 && ready_s2;

	assign row_end   = col_q >= dims.last_col;
	assign frame_end = row_end && (row_q >= dims.last_row);
	assign hit       = (row_q >= CNT_W'(2)) && (col_q >= CNT_W'(2)) &&
	                   (row_q <= dims.last_row) && (col_q <= dims.last_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				row_q <= '0;
				col_q <= '0;
			end else if (row_end) begin
				row_q <= row_q + CNT_W'(1);
				col_q <= '0;
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	// two potential banks picked by row parity, plus the density delay line
	jps_ram #(.WIDTH(VAL_W), .DEPTH(LINE_LEN)) u_bank0 (
		.clk   (clk),
		.we    (accept && !row_q[0]),
		.waddr (col_q[ADDR_W-1:0]),
		.wdata (item.old_value),
		.re    (accept),
		.raddr (col_q[ADDR_W-1:0]),
		.rdata (rd0)
	);

	jps_ram #(.WIDTH(VAL_W), .DEPTH(LINE_LEN)) u_bank1 (
		.clk   (clk),
		.we    (accept && row_q[0]),
		.waddr (col_q[ADDR_W-1:0]),
		.wdata (item.old_value),
		.re    (accept),
		.raddr (col_q[ADDR_W-1:0]),
		.rdata (rd1)
	);

	jps_ram #(.WIDTH(VAL_W), .DEPTH(LINE_LEN)) u_dens (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q[ADDR_W-1:0]),
		.wdata (item.density_value),
		.re    (accept),
		.raddr (col_q[ADDR_W-1:0]),
		.rdata (rdd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bank_s1                 <= row_q[0];
			hit_s1                  <= hit;
			tag_s1.row_index        <= IDX_W'(row_q - CNT_W'(2));
			tag_s1.column_index     <= IDX_W'(col_q - CNT_W'(2));
			tag_s1.frame_last       <= (row_q == dims.last_row) && (col_q == dims.last_col);
			x_s1                    <= item.old_value;
		end
	end

	// mid row is the other bank; own bank still holds the row two above
	assign mid_rd = bank_s1 ? rd0 : rd1;
	assign up_rd  = bank_s1 ? rd1 : rd0;

	always_ff @(posedge clk) begin
		if (pass_s1) begin
			r2_q <= r1_q;
			r1_q <= mid_rd;
			u1_q <= up_rd;
			x1_q <= x_s1;
			d1_q <= rdd;
			opnd_s2.hsum <= $signed({r2_q[VAL_W-1], r2_q}) + $signed({mid_rd[VAL_W-1], mid_rd});
			opnd_s2.vsum <= $signed({u1_q[VAL_W-1], u1_q}) + $signed({x1_q[VAL_W-1], x1_q});
			opnd_s2.rho  <= d1_q;
			opnd_s2.tag  <= tag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1 && hit_s1;
		end
	end

	assign opnd_valid = valid_s2;
	assign opnd       = opnd_s2;

endmodule

>>> src/jps_arith.sv
`timescale 1ns / 1ps
module jps_arith (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             opnd_valid,
	output logic             opnd_ready,
	input  jps_pkg::opnd_t   opnd,
	input  jps_pkg::dims_t   dims,
	output logic             result_valid,
	input  logic             result_stall,
	output jps_pkg::result_t result
);
	import jps_pkg::*;

	localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (COEF_FRAC - 1);
	localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'(33'sh0_7FFF_FFFF);
	localparam logic signed [Q_W-1:0]   Q_MIN = Q_W'(-33'sh0_8000_0000);

	logic ready_s3, ready_s4, ready_q;

	logic                    valid_s3;
	logic signed [PH_W-1:0]  ph_s3, pv_s3;
	logic signed [PD_W-1:0]  pd_s3;
	tag_t                    tag_s3;

	logic                    valid_s4;
	logic signed [ACC_W-1:0] acc_s4;
	tag_t                    tag_s4;

	logic                    valid_q;
	result_t                 result_q;

	logic signed [PH_W-1:0]  ph, pv;
	logic signed [PD_W-1:0]  pd;
	logic signed [ACC_W-1:0] acc;
	logic signed [Q_W-1:0]   q;
	logic [VAL_W-1:0]        sat;

	assign ready_q    = !valid_q || !result_stall;
	assign ready_s4   = !valid_s4 || ready_q;
	assign ready_s3   = !valid_s3 || ready_s4;
	assign opnd_ready = ready_s3;

	assign ph = PH_W'(opnd.hsum) * PH_W'($signed({1'b0, dims.coef_h}));
	assign pv = PH_W'(opnd.vsum) * PH_W'($signed({1'b0, dims.coef_v}));
	assign pd = PD_W'(opnd.rho) * PD_W'($signed({1'b0, dims.coef_d}));

	// exact sum, rounding bias folded in; the final clamp covers any overflow
	assign acc = ACC_W'(ph_s3) + ACC_W'(pv_s3) - ACC_W'(pd_s3) + HALF;

	assign q = Q_W'(acc_s4 >>> COEF_FRAC);

	always_comb begin
		if (q > Q_MAX) begin
			sat = VAL_W'(Q_MAX);
		end else if (q < Q_MIN) begin
			sat = VAL_W'(Q_MIN);
		end else begin
			sat = q[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= opnd_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_q) begin
				valid_q <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && opnd_valid) begin
			ph_s3  <= ph;
			pv_s3  <= pv;
			pd_s3  <= pd;
			tag_s3 <= opnd.tag;
		end
		if (ready_s4 && valid_s3) begin
			acc_s4 <= acc;
			tag_s4 <= tag_s3;
		end
		if (ready_q && valid_s4) begin
			result_q.new_value    <= sat;
			result_q.row_index    <= tag_s4.row_index;
			result_q.column_index <= tag_s4.column_index;
			result_q.frame_last   <= tag_s4.frame_last;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

>>> src/jacobi_poisson_stencil_top.sv
// Throughput: one grid item per cycle while item_stall is low; each item is a single write
// and read of the line stores. A cell's result enters the output register through the window,
// operand, product, sum registers once the item one padded row and column past it is accepted.
// Every stage has its own valid and advances when the stage after it is empty or moving.
// Reset clears the row/column counters and all valid bits and loads the register defaults;
// the line stores have no reset and need no clearing pass.
`timescale 1ns / 1ps
module jacobi_poisson_stencil_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  jps_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output jps_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [jps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jps_pkg::CFG_DATA_W-1:0] cfg_data
);
	import jps_pkg::*;

	dims_t dims;
	logic  opnd_valid, opnd_ready;
	opnd_t opnd;

	jps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dims      (dims)
	);

	jps_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.dims       (dims),
		.opnd_valid (opnd_valid),
		.opnd_ready (opnd_ready),
		.opnd       (opnd)
	);

	jps_arith u_arith (
		.clk          (clk),
		.arst_n       (arst_n),
		.opnd_valid   (opnd_valid),
		.opnd_ready   (opnd_ready),
		.opnd         (opnd),
		.dims         (dims),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
